FILE: rtl/sphere_vertex_generator_assert.svh
// Assertion macros shared by the sphere vertex generator RTL.
// Each use expects clk and rst_n in scope.
`ifndef SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`define SPHERE_VERTEX_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every edge outside reset.
`define SVG_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("svg assertion failed");
// Condition in one cycle implies the consequence in the next.
`define SVG_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("svg assertion failed");
`else
`define SVG_ASSERT(label, expr)
`define SVG_ASSERT_NEXT(label, cond, conseq)
`endif

`endif

FILE: rtl/svg_pkg.sv
`timescale 1ns / 1ps
package svg_pkg;

  localparam int SEC_W = 11;
  localparam int IDX_W = 11;
  localparam int RAD_W = 16;
  localparam int OUT_W = 17;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  // long division: 44-bit dividend, 4 quotient bits per stage
  localparam int DVD_W = 44;
  localparam int QUO_W = 32;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STAGES = DVD_W / DIV_STEPS;

  localparam int F_W = 30;
  localparam int MAG_W = 31;
  localparam int Q30_SH = 30;
  localparam logic [MAG_W-1:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  localparam int POLY_N = 5;
  localparam int unsigned SDIV [POLY_N] = '{6, 20, 42, 72, 110};
  localparam int unsigned CDIV [POLY_N] = '{2, 12, 30, 56, 90};

  localparam int SC_STAGES = 5 + 2 * POLY_N;
  localparam int TAIL_STAGES = 4;
  localparam int PIPE_DEPTH = DIV_STAGES + SC_STAGES + TAIL_STAGES;

  localparam int OUT_LIMIT = 65535;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAT_SECTORS = 2'd0,
    CFG_LON_SECTORS = 2'd1,
    CFG_RADIUS      = 2'd2
  } cfg_idx_t;

  // sine/cosine in sign-magnitude, Q30 magnitudes
  typedef struct packed {
    logic             s_neg;
    logic             c_neg;
    logic [MAG_W-1:0] s_mag;
    logic [MAG_W-1:0] c_mag;
  } sc_t;

endpackage

FILE: rtl/svg_if.sv
`timescale 1ns / 1ps
interface svg_in_if import svg_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] lat_index;
  logic [IDX_W-1:0] lon_index;

  modport source (output valid, output lat_index, output lon_index, input ready);
  modport sink   (input valid, input lat_index, input lon_index, output ready);
endinterface

interface svg_out_if import svg_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] pos_x;
  logic signed [OUT_W-1:0] pos_y;
  logic signed [OUT_W-1:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

FILE: rtl/svg_div.sv
`timescale 1ns / 1ps
module svg_div import svg_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dividend,
  input  logic [SEC_W-1:0] divisor,
  output logic [QUO_W-1:0] quotient
);

  logic [SEC_W-1:0] rem_r [DIV_STAGES];
  logic [QUO_W-1:0] quo_r [DIV_STAGES];
  logic [DVD_W-1:0] dvd_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [SEC_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [DVD_W-1:0] dvd_in;
    logic [SEC_W-1:0] rem_nxt;
    logic [QUO_W-1:0] quo_nxt;
    logic [DVD_W-1:0] dvd_nxt;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign dvd_in = dividend;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign dvd_in = dvd_r[k-1];
    end

    // restoring division, remainder stays below divisor
    always_comb begin
      logic [SEC_W:0] r2;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int i = 0; i < DIV_STEPS; i++) begin
        r2 = {rem_nxt, dvd_in[DVD_W-1-i]};
        if (r2 >= {1'b0, divisor}) begin
          rem_nxt = SEC_W'(r2 - {1'b0, divisor});
          quo_nxt = {quo_nxt[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = r2[SEC_W-1:0];
          quo_nxt = {quo_nxt[QUO_W-2:0], 1'b0};
        end
      end
      dvd_nxt = dvd_in << DIV_STEPS;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
        dvd_r[k] <= dvd_nxt;
      end
    end
  end

  assign quotient = quo_r[DIV_STAGES-1];

endmodule

FILE: rtl/svg_sincos.sv
`timescale 1ns / 1ps
module svg_sincos import svg_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] phase,
  output sc_t         sc
);

  localparam int HS = 2 * POLY_N;

  logic [2:0]     oct1_r, oct2_r, oct3_r, oct14_r;
  logic [F_W-1:0] f1_r, x2_r, x3_r, sq3_r;
  logic [F_W-1:0] s0_r;
  logic [MAG_W-1:0] c0_r;
  sc_t            sc_r;

  logic [2:0]     hoct_r [HS];
  logic [F_W-1:0] hx_r   [HS];
  logic [F_W-1:0] hsq_r  [HS];
  logic [F_W-1:0] sa_r   [POLY_N];
  logic [F_W-1:0] ca_r   [POLY_N];
  logic [MAG_W-1:0] st_r [POLY_N];
  logic [MAG_W-1:0] ct_r [POLY_N];

  logic [F_W-1:0] f_nxt;
  logic [61:0]    xprod;
  logic [59:0]    sqprod;
  logic [60:0]    s0prod;

  // octant fold: odd octants measure from the far edge
  always_comb begin
    f_nxt = {1'b0, phase[28:0]};
    if (phase[29]) begin
      f_nxt = F_W'(30'h2000_0000 - {1'b0, phase[28:0]});
    end
  end

  assign xprod  = 62'(f1_r) * 62'(PI_Q30);
  assign sqprod = 60'(x2_r) * 60'(x2_r);
  assign s0prod = 61'(hx_r[HS-1]) * 61'(st_r[POLY_N-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      oct1_r  <= phase[31:29];
      f1_r    <= f_nxt;
      oct2_r  <= oct1_r;
      x2_r    <= xprod[60:31];
      oct3_r  <= oct2_r;
      x3_r    <= x2_r;
      sq3_r   <= sqprod[59:30];
      oct14_r <= hoct_r[HS-1];
      s0_r    <= s0prod[59:30];
      c0_r    <= ct_r[POLY_N-1];
      sc_r.s_neg <= oct14_r[2];
      sc_r.c_neg <= oct14_r[2] ^ oct14_r[1];
      if (oct14_r[0] ^ oct14_r[1]) begin
        sc_r.s_mag <= c0_r;
        sc_r.c_mag <= {1'b0, s0_r};
      end else begin
        sc_r.s_mag <= {1'b0, s0_r};
        sc_r.c_mag <= c0_r;
      end
    end
  end

  // carried operands through the Horner stages
  for (genvar h = 0; h < HS; h++) begin : g_carry
    if (h == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          hoct_r[h] <= oct3_r;
          hx_r[h]   <= x3_r;
          hsq_r[h]  <= sq3_r;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          hoct_r[h] <= hoct_r[h-1];
          hx_r[h]   <= hx_r[h-1];
          hsq_r[h]  <= hsq_r[h-1];
        end
      end
    end
  end

  // one Horner step per two stages: product, then multiply by reciprocal
  for (genvar j = 0; j < POLY_N; j++) begin : g_horner
    localparam int unsigned SD = SDIV[POLY_N-1-j];
    localparam int unsigned CD = CDIV[POLY_N-1-j];
    localparam int unsigned SL = $clog2(SD);
    localparam int unsigned CL = $clog2(CD);
    localparam logic [63:0] SM = ((64'd1 << (Q30_SH + SL)) + 64'(SD) - 64'd1) / 64'(SD);
    localparam logic [63:0] CM = ((64'd1 << (Q30_SH + CL)) + 64'(CD) - 64'd1) / 64'(CD);

    logic [F_W-1:0]   sq_in;
    logic [MAG_W-1:0] st_in, ct_in;
    logic [60:0]      sp, cp;
    logic [61:0]      sqp, cqp;
    logic [F_W-1:0]   sq, cq;

    if (j == 0) begin : g_first
      assign sq_in = sq3_r;
      assign st_in = Q30_ONE;
      assign ct_in = Q30_ONE;
    end else begin : g_next
      assign sq_in = hsq_r[2*j-1];
      assign st_in = st_r[j-1];
      assign ct_in = ct_r[j-1];
    end

    assign sp  = 61'(sq_in) * 61'(st_in);
    assign cp  = 61'(sq_in) * 61'(ct_in);
    assign sqp = 62'(sa_r[j]) * 62'(SM[31:0]);
    assign cqp = 62'(ca_r[j]) * 62'(CM[31:0]);
    assign sq  = F_W'(sqp >> (Q30_SH + SL));
    assign cq  = F_W'(cqp >> (Q30_SH + CL));

    always_ff @(posedge clk) begin
      if (en) begin
        sa_r[j] <= sp[59:30];
        ca_r[j] <= cp[59:30];
        st_r[j] <= Q30_ONE - {1'b0, sq};
        ct_r[j] <= Q30_ONE - {1'b0, cq};
      end
    end
  end

  assign sc = sc_r;

endmodule

FILE: rtl/sphere_vertex_generator.sv
`timescale 1ns / 1ps
// UV sphere vertex generator.
// in_if carries a latitude and longitude step index; out_if returns the
// vertex (pos_x, pos_y, pos_z) in signed Q8.8, one result per transfer.
// The cfg port writes lat_sectors (0), lon_sectors (1) and radius (2);
// write it only while no item is in flight. Other indexes are ignored.
// Throughput: one item per cycle while the output is not stalled. An item
// passes 11 long-division stages, 15 sine/cosine stages of polynomial
// evaluation and 4 radius scaling and rounding stages to out_if.valid.
// The whole pipeline advances as one: when the output holds a result the
// receiver does not take, every stage holds and in_if.ready drops in the
// same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads lat_sectors 16, lon_sectors 32,
// radius 1.0; the block takes an item in the first cycle after reset.
module sphere_vertex_generator import svg_pkg::*; #(
  parameter int MAX_SECTORS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  svg_in_if.sink               in_if,
  svg_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int MaxEff = (MAX_SECTORS > 2047) ? 2047 : MAX_SECTORS;
  localparam logic [SEC_W-1:0] MAX_EFF = SEC_W'(MaxEff);

  logic [SEC_W-1:0] lat_sectors_r, lon_sectors_r;
  logic [RAD_W-1:0] radius_r;
  logic [SEC_W-1:0] lat_eff, lon_eff;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic en;

  logic [DVD_W-1:0] lat_dvd, lon_dvd;
  logic [QUO_W-1:0] lat_q, lon_q;
  logic [31:0]      lat_ph;
  sc_t              lat_sc, lon_sc;

  // tail stages
  logic [46:0]      yp_r, xp_r;
  logic             ys1_r, xzs1_r, ys2_r, xzs2_r, ys3_r;
  sc_t              lon1_r, lon2_r;
  logic [16:0]      ymag2_r, ymag3_r;
  logic [MAG_W-1:0] xz2_r;
  logic [61:0]      px_r, pz_r;
  logic             xs3_r, zs3_r;
  logic signed [OUT_W-1:0] pos_x_r, pos_y_r, pos_z_r;

  logic [47:0] y_sum, xz_sum;
  logic [62:0] px_sum, pz_sum;
  logic [18:0] x_mag, z_mag;

  function automatic logic [SEC_W-1:0] eff_sec(input logic [SEC_W-1:0] v,
                                               input logic [SEC_W-1:0] mx);
    if (v == '0) return SEC_W'(1);
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic [18:0] m,
                                                      input logic neg);
    logic [OUT_W-1:0] lim;
    lim = (m > 19'(OUT_LIMIT)) ? OUT_W'(OUT_LIMIT) : m[OUT_W-1:0];
    return neg ? -lim : lim;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_sectors_r <= SEC_W'(16);
      lon_sectors_r <= SEC_W'(32);
      radius_r      <= RAD_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_LAT_SECTORS: lat_sectors_r <= cfg_wdata[SEC_W-1:0];
        CFG_LON_SECTORS: lon_sectors_r <= cfg_wdata[SEC_W-1:0];
        CFG_RADIUS:      radius_r      <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign lat_eff = eff_sec(lat_sectors_r, MAX_EFF);
  assign lon_eff = eff_sec(lon_sectors_r, MAX_EFF);

  assign en          = !vld_r[PIPE_DEPTH-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_if.valid};
    end
  end

  // index * 2^31 (or 2^32) plus half the divisor, divided by the sector count
  assign lat_dvd = {2'b0, in_if.lat_index, 21'b0, lat_eff[SEC_W-1:1]};
  assign lon_dvd = {1'b0, in_if.lon_index, 22'b0, lon_eff[SEC_W-1:1]};

  svg_div u_lat_div (
    .clk      (clk),
    .en       (en),
    .dividend (lat_dvd),
    .divisor  (lat_eff),
    .quotient (lat_q)
  );

  svg_div u_lon_div (
    .clk      (clk),
    .en       (en),
    .dividend (lon_dvd),
    .divisor  (lon_eff),
    .quotient (lon_q)
  );

  // latitude starts at the north pole, quarter turn
  assign lat_ph = 32'h4000_0000 - lat_q;

  svg_sincos u_lat_sc (
    .clk   (clk),
    .en    (en),
    .phase (lat_ph),
    .sc    (lat_sc)
  );

  svg_sincos u_lon_sc (
    .clk   (clk),
    .en    (en),
    .phase (lon_q),
    .sc    (lon_sc)
  );

  // rounding on magnitudes gives ties away from zero
  assign y_sum  = 48'(yp_r) + 48'h0000_2000_0000;
  assign xz_sum = 48'(xp_r) + 48'h0000_0000_8000;
  assign px_sum = 63'(px_r) + (63'd1 << 43);
  assign pz_sum = 63'(pz_r) + (63'd1 << 43);
  assign x_mag  = 19'(px_sum >> 44);
  assign z_mag  = 19'(pz_sum >> 44);

  always_ff @(posedge clk) begin
    if (en) begin
      yp_r    <= 47'(radius_r) * 47'(lat_sc.s_mag);
      xp_r    <= 47'(radius_r) * 47'(lat_sc.c_mag);
      ys1_r   <= lat_sc.s_neg;
      xzs1_r  <= lat_sc.c_neg;
      lon1_r  <= lon_sc;

      ymag2_r <= 17'(y_sum >> 30);
      xz2_r   <= MAG_W'(xz_sum >> 16);
      ys2_r   <= ys1_r;
      xzs2_r  <= xzs1_r;
      lon2_r  <= lon1_r;

      px_r    <= 62'(xz2_r) * 62'(lon2_r.c_mag);
      pz_r    <= 62'(xz2_r) * 62'(lon2_r.s_mag);
      xs3_r   <= xzs2_r ^ lon2_r.c_neg;
      zs3_r   <= xzs2_r ^ lon2_r.s_neg;
      ymag3_r <= ymag2_r;
      ys3_r   <= ys2_r;

      pos_x_r <= sat_out(x_mag, xs3_r);
      pos_y_r <= sat_out({2'b0, ymag3_r}, ys3_r);
      pos_z_r <= sat_out(z_mag, zs3_r);
    end
  end

  assign out_if.valid = vld_r[PIPE_DEPTH-1];
  assign out_if.pos_x = pos_x_r;
  assign out_if.pos_y = pos_y_r;
  assign out_if.pos_z = pos_z_r;

`include "sphere_vertex_generator_assert.svh"

  `SVG_ASSERT_NEXT(a_in_enters, in_if.valid && in_if.ready, vld_r[0])
  `SVG_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_r))
  `SVG_ASSERT(a_out_range, !out_if.valid || (out_if.pos_x != 17'h10000 && out_if.pos_y != 17'h10000 && out_if.pos_z != 17'h10000))

endmodule

FILE: tb/sv/sphere_vertex_generator_tb.sv
`timescale 1ns / 1ps
module sphere_vertex_generator_tb;
  import svg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 5000;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef struct {
    logic [IDX_W-1:0] lat;
    logic [IDX_W-1:0] lon;
  } idx_pair_t;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } vertex_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  svg_in_if in_ch ();
  svg_out_if out_ch ();

  sphere_vertex_generator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // local copy of the register file
  logic [SEC_W-1:0] lat_sec_q;
  logic [SEC_W-1:0] lon_sec_q;
  logic [RAD_W-1:0] radius_q;

  idx_pair_t pending_idx[$];
  vertex_t   vertex_q[$];
  int        fail_cnt;
  int        burst_left;
  int        gap_left;
  int        stall_mode;
  int        mode_cycles;
  int        idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned clamp_sectors(logic [SEC_W-1:0] v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return v;
  endfunction

  function automatic longint unsigned taylor_q30(longint unsigned x2, bit use_sin);
    longint unsigned t;
    longint unsigned d;
    t = ONE_Q30;
    for (int k = POLY_N - 1; k >= 0; k--) begin
      d = use_sin ? SDIV[k] : CDIV[k];
      t = ONE_Q30 - ((x2 * t) >> 30) / d;
    end
    return t;
  endfunction

  function automatic void phase_sin_cos(input logic [31:0] ph,
                                        output longint s, output longint c);
    logic [2:0] oct;
    longint unsigned f;
    longint unsigned xr;
    longint unsigned x2;
    longint s0;
    longint c0;
    oct = ph[31:29];
    f = ph[28:0];
    if (oct[0]) f = (64'd1 << 29) - f;
    xr = (f * 64'd3373259426) >> 31;
    x2 = (xr * xr) >> 30;
    s0 = longint'((xr * taylor_q30(x2, 1'b1)) >> 30);
    c0 = longint'(taylor_q30(x2, 1'b0));
    case (oct)
      3'd0: begin s = s0;  c = c0;  end
      3'd1: begin s = c0;  c = s0;  end
      3'd2: begin s = c0;  c = -s0; end
      3'd3: begin s = s0;  c = -c0; end
      3'd4: begin s = -s0; c = -c0; end
      3'd5: begin s = -c0; c = -s0; end
      3'd6: begin s = -c0; c = s0;  end
      default: begin s = -s0; c = c0; end
    endcase
  endfunction

  function automatic longint round_away(longint v, int sh);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_q8_8(longint v);
    if (v > OUT_LIMIT) v = OUT_LIMIT;
    if (v < -OUT_LIMIT) v = -OUT_LIMIT;
    return v[OUT_W-1:0];
  endfunction

  function automatic vertex_t vertex_of(idx_pair_t p);
    longint unsigned ls;
    longint unsigned os;
    longint unsigned li;
    longint unsigned oi;
    logic [31:0] lat_ph;
    logic [31:0] lon_ph;
    longint slat, clat, slon, clon, xz;
    vertex_t v;
    ls = clamp_sectors(lat_sec_q);
    os = clamp_sectors(lon_sec_q);
    li = p.lat;
    oi = p.lon;
    lat_ph = 32'((64'd1 << 30) - ((li << 31) + (ls >> 1)) / ls);
    lon_ph = 32'(((oi << 32) + (os >> 1)) / os);
    phase_sin_cos(lat_ph, slat, clat);
    phase_sin_cos(lon_ph, slon, clon);
    xz = round_away(longint'(radius_q) * clat, 16);
    v.x = sat_q8_8(round_away(xz * clon, 44));
    v.y = sat_q8_8(round_away(longint'(radius_q) * slat, 30));
    v.z = sat_q8_8(round_away(xz * slon, 44));
    return v;
  endfunction

  // sender: bursts with random gaps
  always @(posedge clk) begin
    idx_pair_t p;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.lat_index <= '0;
      in_ch.lon_index <= '0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        vertex_q.push_back(vertex_of('{in_ch.lat_index, in_ch.lon_index}));
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_idx.size() > 0) begin
          p = pending_idx.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.lat_index <= p.lat;
          in_ch.lon_index <= p.lon;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches mode every so often
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_mode <= 0;
      mode_cycles <= 0;
    end else begin
      if (mode_cycles == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_cycles <= $urandom_range(20, 120);
      end else begin
        mode_cycles <= mode_cycles - 1;
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 9) < 7);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (mode_cycles % 5 != 0);
      endcase
    end
  end

  // checker
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (vertex_q.size() == 0) begin
        $error("unexpected result transfer x=%0d y=%0d z=%0d",
               out_ch.pos_x, out_ch.pos_y, out_ch.pos_z);
        fail_cnt++;
      end else begin
        e = vertex_q.pop_front();
        if (out_ch.pos_x !== e.x) begin
          $error("pos_x expected %0d actual %0d", e.x, out_ch.pos_x);
          fail_cnt++;
        end
        if (out_ch.pos_y !== e.y) begin
          $error("pos_y expected %0d actual %0d", e.y, out_ch.pos_y);
          fail_cnt++;
        end
        if (out_ch.pos_z !== e.z) begin
          $error("pos_z expected %0d actual %0d", e.z, out_ch.pos_z);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer while work is outstanding
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (pending_idx.size() == 0 && vertex_q.size() == 0 && !in_ch.valid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    if (idx == CFG_LAT_SECTORS) lat_sec_q = val[SEC_W-1:0];
    else if (idx == CFG_LON_SECTORS) lon_sec_q = val[SEC_W-1:0];
    else if (idx == CFG_RADIUS) radius_q = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sphere(logic [CFG_W-1:0] lat_s, logic [CFG_W-1:0] lon_s,
                            logic [CFG_W-1:0] rad);
    write_reg(CFG_LAT_SECTORS, lat_s);
    write_reg(CFG_LON_SECTORS, lon_s);
    write_reg(CFG_RADIUS, rad);
    // bogus index must leave everything alone
    write_reg(CFG_IDX_NONE, 16'($urandom));
  endtask

  task automatic wait_drained();
    while (pending_idx.size() > 0 || in_ch.valid || vertex_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_pair(int lat, int lon);
    pending_idx.push_back('{IDX_W'(lat), IDX_W'(lon)});
  endtask

  // mostly in-range grid points, some raw 11-bit indexes that wrap
  task automatic add_grid(int n);
    int ls;
    int os;
    ls = clamp_sectors(lat_sec_q);
    os = clamp_sectors(lon_sec_q);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0)
        add_pair($urandom_range(0, 2047), $urandom_range(0, 2047));
      else
        add_pair($urandom_range(0, ls), $urandom_range(0, os));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_LAT_SECTORS;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.lat_index = '0;
    in_ch.lon_index = '0;
    out_ch.ready = 1'b0;
    fail_cnt = 0;
    idle_cycles = 0;
    lat_sec_q = 16;
    lon_sec_q = 32;
    radius_q = 256;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: poles, equator, quadrants, wrap past the sector count
    add_pair(0, 0);
    add_pair(16, 0);
    add_pair(8, 0);
    add_pair(8, 8);
    add_pair(8, 16);
    add_pair(8, 24);
    add_pair(8, 32);
    add_pair(4, 4);
    add_pair(12, 28);
    add_pair(1, 1);
    add_pair(15, 31);
    add_pair(17, 33);
    add_pair(32, 64);
    add_pair(1024, 1024);
    add_pair(2047, 2047);
    add_pair(1365, 682);
    add_pair(682, 1365);
    add_pair(0, 2047);
    add_pair(2047, 0);
    add_pair(3, 5);
    add_grid(180);
    wait_drained();

    // zero sectors act as one, radius zero
    set_sphere(16'h0000, 16'h0000, 16'h0000);
    add_grid(180);
    wait_drained();

    // largest legal settings, full radius
    set_sphere(16'd1024, 16'd1024, 16'hFFFF);
    add_grid(220);
    wait_drained();

    // above the sector limit, upper data bits set
    set_sphere(16'hFFFF, 16'hF7FF, 16'h8001);
    add_grid(180);
    wait_drained();

    set_sphere(16'd1, 16'd1, 16'h0100);
    add_grid(150);
    wait_drained();

    set_sphere(16'd2, 16'd3, 16'h7FFF);
    add_grid(180);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      set_sphere(16'($urandom_range(0, 2047)) | 16'($urandom_range(0, 31) << 11),
                 16'($urandom_range(0, 2047)), 16'($urandom));
      add_grid(180);
      wait_drained();
    end

    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
